/* hw/rtl/nfs_pkg.sv */
// nfs_pkg: shared types and constants for the nearest five-smooth search
`default_nettype none
package nfs_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PROD_W  = 2 * VALUE_W;

    // largest 5-smooth number that fits in 32 bits
    localparam logic [VALUE_W-1:0] SMOOTH_CLAMP = 32'd4271484375;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQUARE,
        ST_PRODUCT,
        ST_FINISH
    } nfs_state_t;

    // next point of the 2^a * 3^b * 5^c walk
    typedef struct packed {
        logic [VALUE_W-1:0] cand;
        logic [VALUE_W-1:0] row;
        logic [VALUE_W-1:0] col;
        logic               last;
    } nfs_step_t;

endpackage
`default_nettype wire

/* hw/rtl/nfs_step.sv */
// nfs_step: advances the candidate walk over all 5-smooth numbers by one point
`default_nettype none
module nfs_step
    import nfs_pkg::*;
(
    input  wire logic [VALUE_W-1:0] cand,
    input  wire logic [VALUE_W-1:0] row,
    input  wire logic [VALUE_W-1:0] col,
    output nfs_step_t               step
);

    logic [VALUE_W+2:0] cand5;
    logic [VALUE_W+1:0] row3;
    logic [VALUE_W:0]   col2;

    assign cand5 = {3'b000, cand} + {1'b0, cand, 2'b00};
    assign row3  = {2'b00, row} + {1'b0, row, 1'b0};
    assign col2  = {col, 1'b0};

    always_comb begin
        step.cand = cand;
        step.row  = row;
        step.col  = col;
        step.last = 1'b0;
        if (cand5 <= {3'b000, SMOOTH_CLAMP}) begin
            step.cand = cand5[VALUE_W-1:0];
        end else if (row3 <= {2'b00, SMOOTH_CLAMP}) begin
            step.row  = row3[VALUE_W-1:0];
            step.cand = row3[VALUE_W-1:0];
        end else if (col2 <= {1'b0, SMOOTH_CLAMP}) begin
            step.col  = col2[VALUE_W-1:0];
            step.row  = col2[VALUE_W-1:0];
            step.cand = col2[VALUE_W-1:0];
        end else begin
            step.last = 1'b1;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/nearest_five_smooth.sv */
// nearest_five_smooth: nearest 5-smooth number and smoothness flag of a 32-bit value
//
//   channel   ports                                 width   direction
//   input     s_valid s_ready s_value_in            32      in
//   result    m_valid m_ready m_nearest_smooth      32      out
//             m_input_is_smooth                     1       out
//
// one transfer runs through the accepting cycle, the candidate walk over each 5-smooth number
// up to the clamp (1,848 of them), the square and then the bounds product on the shared
// 32x32 multiplier, and the finish step that picks and loads the result register
// reset is synchronous and returns the sequencer to idle with no result pending
// s_ready is high only in idle; the finish step waits while a result is unread
`default_nettype none
module nearest_five_smooth
    import nfs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [VALUE_W-1:0]      m_nearest_smooth,
    output logic                    m_input_is_smooth
);

    nfs_state_t state_reg, state_next;

    logic [VALUE_W-1:0] raw_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] cand_reg;
    logic [VALUE_W-1:0] row_reg;
    logic [VALUE_W-1:0] col_reg;
    logic [VALUE_W-1:0] upper_reg;
    logic [VALUE_W-1:0] lower_reg;
    logic               smooth_reg;
    logic [PROD_W-1:0]  sq_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] out_val_reg;
    logic               out_smooth_reg;
    logic               m_valid_reg;

    logic               in_xfer;
    logic               out_free;
    logic               scan_en;
    logic               load_sq;
    logic               load_prod;
    logic               out_load;
    logic [VALUE_W-1:0] val_clamped;
    logic [VALUE_W-1:0] mul_a;
    logic [VALUE_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    nfs_step_t          step;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (s_value_in > SMOOTH_CLAMP) begin
            val_clamped = SMOOTH_CLAMP;
        end else if (s_value_in == '0) begin
            val_clamped = VALUE_W'(1);
        end else begin
            val_clamped = s_value_in;
        end
    end

    nfs_step u_step (
        .cand (cand_reg),
        .row  (row_reg),
        .col  (col_reg),
        .step (step)
    );

    // shared multiplier: square of the value, then product of the bounds
    always_comb begin
        if (state_reg == ST_SQUARE) begin
            mul_a = val_reg;
            mul_b = val_reg;
        end else begin
            mul_a = upper_reg;
            mul_b = lower_reg;
        end
    end
    assign mul_p = {{VALUE_W{1'b0}}, mul_a} * {{VALUE_W{1'b0}}, mul_b};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step.last) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_PRODUCT;
            end
            ST_PRODUCT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        scan_en   = 1'b0;
        load_sq   = 1'b0;
        load_prod = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                scan_en = 1'b1;
            end
            ST_SQUARE: begin
                load_sq = 1'b1;
            end
            ST_PRODUCT: begin
                load_prod = 1'b1;
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            raw_reg    <= s_value_in;
            val_reg    <= val_clamped;
            cand_reg   <= VALUE_W'(1);
            row_reg    <= VALUE_W'(1);
            col_reg    <= VALUE_W'(1);
            upper_reg  <= SMOOTH_CLAMP;
            lower_reg  <= VALUE_W'(1);
            smooth_reg <= 1'b0;
        end
        if (scan_en) begin
            if (cand_reg >= val_reg && cand_reg < upper_reg) begin
                upper_reg <= cand_reg;
            end
            if (cand_reg <= val_reg && cand_reg > lower_reg) begin
                lower_reg <= cand_reg;
            end
            if (cand_reg == raw_reg) begin
                smooth_reg <= 1'b1;
            end
            cand_reg <= step.cand;
            row_reg  <= step.row;
            col_reg  <= step.col;
        end
        if (load_sq) begin
            sq_reg <= mul_p;
        end
        if (load_prod) begin
            prod_reg <= mul_p;
        end
        if (out_load) begin
            out_val_reg    <= (sq_reg > prod_reg) ? upper_reg : lower_reg;
            out_smooth_reg <= smooth_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_nearest_smooth  = out_val_reg;
    assign m_input_is_smooth = out_smooth_reg;

endmodule
`default_nettype wire
